>>> src/ffba_pkg.sv
package ffba_pkg;

  localparam int FREE_ENTRIES = 32;
  localparam int USED_ENTRIES = 32;
  localparam int OFF_W        = 20;
  localparam int LEN_W        = 21;
  localparam int SIZE_W       = LEN_W + 1;
  localparam int GRAIN        = 8;

  localparam int FREE_IW = $clog2(FREE_ENTRIES);
  localparam int FREE_CW = $clog2(FREE_ENTRIES + 1);
  localparam int USED_IW = $clog2(USED_ENTRIES);
  localparam int USED_CW = $clog2(USED_ENTRIES + 1);

  localparam logic [LEN_W-1:0] REGION_RESET = LEN_W'(65536);

  // register word index (paddr[2])
  localparam logic REG_REGION_SIZE = 1'b0;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_NOTALLOC = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [OFF_W-1:0] base;
  } seg_t;

endpackage

>>> src/first_fit_block_allocator.sv
// First-fit allocator of byte offsets in a region of region_size bytes. One
// request beat in, one result beat out. Allocate rounds the size up to a multiple of 8 and
// takes the lowest-address free segment that is large enough, splitting it;
// free looks the offset up in the used table (newest first) and inserts the
// segment into the address-ordered free table without merging. Free and used
// segments live in two 32-entry single-port-read memories; each request walks
// them one entry at a time (read, then check or write back), so the time a
// request takes grows with the entries it scans and shifts; the worst case is
// a free that scans all 32 used entries, shifts 31 of them, then walks and
// shifts the free table. The next request is taken while the previous result
// waits on the output. After reset the block seeds the free table in its init
// state; writing region_size rebuilds the tables at once.
module first_fit_block_allocator
  import ffba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // nbytes[20:0], addr[40:21], zero pad
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // status[1:0], result_addr[21:2], zero pad
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_INIT    = 15'b000000000000010,
    S_A_REQ   = 15'b000000000000100,
    S_A_CHK   = 15'b000000000001000,
    S_A_SH_RD = 15'b000000000010000,
    S_A_SH_WR = 15'b000000000100000,
    S_R_REQ   = 15'b000000001000000,
    S_R_CHK   = 15'b000000010000000,
    S_U_SH_RD = 15'b000000100000000,
    S_U_SH_WR = 15'b000001000000000,
    S_P_REQ   = 15'b000010000000000,
    S_P_CHK   = 15'b000100000000000,
    S_I_SH_RD = 15'b001000000000000,
    S_I_SH_WR = 15'b010000000000000,
    S_DONE    = 15'b100000000000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [LEN_W-1:0]   region_r;
  logic [FREE_CW-1:0] free_cnt_r, free_cnt_nxt;
  logic [USED_CW-1:0] used_cnt_r, used_cnt_nxt;
  logic [FREE_CW-1:0] f_idx_r, f_idx_nxt;
  logic [FREE_CW-1:0] pos_r, pos_nxt;
  logic [USED_CW-1:0] u_idx_r, u_idx_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic [OFF_W-1:0]   addr_r, addr_nxt;
  logic [LEN_W-1:0]   hold_len_r, hold_len_nxt;
  logic [OFF_W-1:0]   where_r, where_nxt;
  status_t            status_r, status_nxt;
  logic               out_valid_r;
  status_t            out_status_r;
  logic [OFF_W-1:0]   out_addr_r;

  seg_t               free_mem [FREE_ENTRIES];
  seg_t               used_mem [USED_ENTRIES];
  seg_t               fr_r, ur_r;
  logic [FREE_IW-1:0] f_raddr, f_waddr;
  logic [USED_IW-1:0] u_raddr, u_waddr;
  logic               f_we, u_we;
  seg_t               f_wdata, u_wdata;

  logic               cfg_wr;
  logic [SIZE_W-1:0]  round_size;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite &
                      (cfg_paddr[2] == REG_REGION_SIZE);
  assign cfg_prdata = (cfg_paddr[2] == REG_REGION_SIZE) ? {11'd0, region_r} : 32'd0;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_addr_r, out_status_r};

  assign round_size = ({1'b0, in_tdata[20:0]} + SIZE_W'(GRAIN - 1)) & ~SIZE_W'(GRAIN - 1);

  always_comb begin
    state_nxt    = state_r;
    free_cnt_nxt = free_cnt_r;
    used_cnt_nxt = used_cnt_r;
    f_idx_nxt    = f_idx_r;
    pos_nxt      = pos_r;
    u_idx_nxt    = u_idx_r;
    size_nxt     = size_r;
    addr_nxt     = addr_r;
    hold_len_nxt = hold_len_r;
    where_nxt    = where_r;
    status_nxt   = status_r;
    f_raddr      = f_idx_r[FREE_IW-1:0];
    u_raddr      = u_idx_r[USED_IW-1:0];
    f_we         = 1'b0;
    f_waddr      = f_idx_r[FREE_IW-1:0];
    f_wdata      = fr_r;
    u_we         = 1'b0;
    u_waddr      = u_idx_r[USED_IW-1:0];
    u_wdata      = ur_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          size_nxt  = round_size;
          addr_nxt  = in_tdata[40:21];
          where_nxt = '0;
          f_idx_nxt = '0;
          u_idx_nxt = used_cnt_r;
          state_nxt = (in_tuser == FUNC_FREE) ? S_R_REQ : S_A_REQ;
        end
      end
      S_INIT: begin
        f_we      = 1'b1;
        f_waddr   = '0;
        f_wdata   = '{len: region_r, base: '0};
        state_nxt = S_IDLE;
      end
      S_A_REQ: begin
        if (f_idx_r >= free_cnt_r) begin
          status_nxt = ST_NOFIT;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if ({1'b0, fr_r.len} >= size_r) begin
          if (used_cnt_r >= USED_CW'(USED_ENTRIES)) begin
            status_nxt = ST_FULL;
            state_nxt  = S_DONE;
          end else begin
            u_we         = 1'b1;
            u_waddr      = used_cnt_r[USED_IW-1:0];
            u_wdata      = '{len: size_r[LEN_W-1:0], base: fr_r.base};
            used_cnt_nxt = used_cnt_r + 1'b1;
            where_nxt    = fr_r.base;
            if ({1'b0, fr_r.len} == size_r) begin
              state_nxt = S_A_SH_RD;
            end else begin
              f_we       = 1'b1;
              f_wdata    = '{len: fr_r.len - size_r[LEN_W-1:0],
                             base: fr_r.base + size_r[OFF_W-1:0]};
              status_nxt = ST_OK;
              state_nxt  = S_DONE;
            end
          end
        end else begin
          f_idx_nxt = f_idx_r + 1'b1;
          state_nxt = S_A_REQ;
        end
      end
      // close the gap left by an exactly fitting segment
      S_A_SH_RD: begin
        if (f_idx_r + 1'b1 < free_cnt_r) begin
          f_raddr   = FREE_IW'(f_idx_r + 1'b1);
          state_nxt = S_A_SH_WR;
        end else begin
          free_cnt_nxt = free_cnt_r - 1'b1;
          status_nxt   = ST_OK;
          state_nxt    = S_DONE;
        end
      end
      S_A_SH_WR: begin
        f_we      = 1'b1;
        f_idx_nxt = f_idx_r + 1'b1;
        state_nxt = S_A_SH_RD;
      end
      S_R_REQ: begin
        if (u_idx_r == '0) begin
          status_nxt = ST_NOTALLOC;
          state_nxt  = S_DONE;
        end else begin
          u_raddr   = USED_IW'(u_idx_r - 1'b1);
          u_idx_nxt = u_idx_r - 1'b1;
          state_nxt = S_R_CHK;
        end
      end
      S_R_CHK: begin
        if (ur_r.base == addr_r) begin
          if (free_cnt_r >= FREE_CW'(FREE_ENTRIES)) begin
            status_nxt = ST_FULL;
            state_nxt  = S_DONE;
          end else begin
            hold_len_nxt = ur_r.len;
            state_nxt    = S_U_SH_RD;
          end
        end else begin
          state_nxt = S_R_REQ;
        end
      end
      S_U_SH_RD: begin
        if (u_idx_r + 1'b1 < used_cnt_r) begin
          u_raddr   = USED_IW'(u_idx_r + 1'b1);
          state_nxt = S_U_SH_WR;
        end else begin
          used_cnt_nxt = used_cnt_r - 1'b1;
          f_idx_nxt    = '0;
          state_nxt    = S_P_REQ;
        end
      end
      S_U_SH_WR: begin
        u_we      = 1'b1;
        u_idx_nxt = u_idx_r + 1'b1;
        state_nxt = S_U_SH_RD;
      end
      // find the first free segment with a higher base
      S_P_REQ: begin
        if (f_idx_r >= free_cnt_r) begin
          pos_nxt   = free_cnt_r;
          state_nxt = S_I_SH_RD;
        end else begin
          state_nxt = S_P_CHK;
        end
      end
      S_P_CHK: begin
        if (fr_r.base > addr_r) begin
          pos_nxt   = f_idx_r;
          f_idx_nxt = free_cnt_r;
          state_nxt = S_I_SH_RD;
        end else begin
          f_idx_nxt = f_idx_r + 1'b1;
          state_nxt = S_P_REQ;
        end
      end
      S_I_SH_RD: begin
        if (f_idx_r > pos_r) begin
          f_raddr   = FREE_IW'(f_idx_r - 1'b1);
          state_nxt = S_I_SH_WR;
        end else begin
          f_we         = 1'b1;
          f_waddr      = pos_r[FREE_IW-1:0];
          f_wdata      = '{len: hold_len_r, base: addr_r};
          free_cnt_nxt = free_cnt_r + 1'b1;
          status_nxt   = ST_OK;
          state_nxt    = S_DONE;
        end
      end
      S_I_SH_WR: begin
        f_we      = 1'b1;
        f_idx_nxt = f_idx_r - 1'b1;
        state_nxt = S_I_SH_RD;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // memories: a config write reseeds entry 0 of the free table
  always_ff @(posedge clk) begin
    if (cfg_wr) begin
      free_mem[0] <= '{len: cfg_pwdata[LEN_W-1:0], base: '0};
    end else if (f_we) begin
      free_mem[f_waddr] <= f_wdata;
    end
    fr_r <= free_mem[f_raddr];
  end

  always_ff @(posedge clk) begin
    if (u_we) begin
      used_mem[u_waddr] <= u_wdata;
    end
    ur_r <= used_mem[u_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      region_r    <= REGION_RESET;
      free_cnt_r  <= FREE_CW'(1);
      used_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && cfg_paddr[2] == REG_REGION_SIZE) begin
        region_r   <= cfg_pwdata[LEN_W-1:0];
        free_cnt_r <= FREE_CW'(1);
        used_cnt_r <= '0;
      end else begin
        free_cnt_r <= free_cnt_nxt;
        used_cnt_r <= used_cnt_nxt;
      end
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    f_idx_r    <= f_idx_nxt;
    pos_r      <= pos_nxt;
    u_idx_r    <= u_idx_nxt;
    size_r     <= size_nxt;
    addr_r     <= addr_nxt;
    hold_len_r <= hold_len_nxt;
    where_r    <= where_nxt;
    status_r   <= status_nxt;
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_status_r <= status_r;
      out_addr_r   <= (status_r == ST_OK) ? where_r : '0;
    end
  end

endmodule

>>> src/ffba_checker.sv
module ffba_checker
  import ffba_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // one request in flight at a time
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // failed requests report offset zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ST_OK |-> out_tdata[21:2] == '0)
    else $error("nonzero offset on failed request");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:22] == 2'b00)
    else $error("result pad bits set");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);
